@@ hdl/eac_pkg.sv @@
// ----------------------------------------------------------------------------
// Environment alarm classifier package
// Shared types, field codes and threshold reset values.
// ----------------------------------------------------------------------------
package eac_pkg;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 40;
  localparam int unsigned InDataWidth  = 56;
  localparam int unsigned OutDataWidth = 24;
  localparam int unsigned HumFieldWidth = 10;

  // Register indexes.
  localparam logic [CfgAddrWidth-1:0] REG_TEMP_CRITICAL      = 3'd0;
  localparam logic [CfgAddrWidth-1:0] REG_TEMP_OPTIMAL_MAX   = 3'd1;
  localparam logic [CfgAddrWidth-1:0] REG_HUMIDITY_LIMITS    = 3'd2;
  localparam logic [CfgAddrWidth-1:0] REG_TILT_CRIT          = 3'd3;
  localparam logic [CfgAddrWidth-1:0] REG_TILT_WARN          = 3'd4;
  localparam logic [CfgAddrWidth-1:0] REG_VIB_CRIT           = 3'd5;
  localparam logic [CfgAddrWidth-1:0] REG_VIB_WARN           = 3'd6;

  // Reset thresholds.
  localparam logic signed [11:0] RST_TEMP_CRITICAL      = 12'sd350;
  localparam logic signed [11:0] RST_TEMP_OPTIMAL_MAX   = 12'sd270;
  localparam logic [39:0]        RST_HUMIDITY_LIMITS    = 40'd752248729800;
  localparam logic [10:0]        RST_TILT_CRIT          = 11'd150;
  localparam logic [10:0]        RST_TILT_WARN          = 11'd50;
  localparam logic [13:0]        RST_VIB_CRIT           = 14'd2000;
  localparam logic [13:0]        RST_VIB_WARN           = 14'd500;

  // Door codes.
  localparam logic [2:0] DOOR_SHUT       = 3'd0;
  localparam logic [2:0] DOOR_UNLOCKED   = 3'd1;
  localparam logic [2:0] DOOR_OPEN_OK    = 3'd2;
  localparam logic [2:0] DOOR_BREACHED   = 3'd3;
  localparam logic [2:0] DOOR_LOCK_FAULT = 3'd4;

  // Overall status codes.
  localparam logic [2:0] STATUS_OFFLINE      = 3'd0;
  localparam logic [2:0] STATUS_OPTIMAL      = 3'd1;
  localparam logic [2:0] STATUS_WARNING      = 3'd2;
  localparam logic [2:0] STATUS_CRITICAL     = 3'd3;
  localparam logic [2:0] STATUS_SENSOR_ERROR = 3'd4;

  // Reason codes.
  localparam logic [4:0] RSN_NET_DOWN        = 5'd0;
  localparam logic [4:0] RSN_CLIMATE_ERR     = 5'd1;
  localparam logic [4:0] RSN_MOTION_ERR      = 5'd2;
  localparam logic [4:0] RSN_DOOR_UNLOCKED   = 5'd3;
  localparam logic [4:0] RSN_DOOR_OPEN_AUTH  = 5'd4;
  localparam logic [4:0] RSN_DOOR_FORCED     = 5'd5;
  localparam logic [4:0] RSN_DOOR_LOCK_ERR   = 5'd6;
  localparam logic [4:0] RSN_TEMP_CRIT       = 5'd7;
  localparam logic [4:0] RSN_HUM_CRIT_LOW    = 5'd8;
  localparam logic [4:0] RSN_HUM_CRIT_HIGH   = 5'd9;
  localparam logic [4:0] RSN_TILT_CRIT       = 5'd10;
  localparam logic [4:0] RSN_VIB_CRIT        = 5'd11;
  localparam logic [4:0] RSN_TEMP_WARN       = 5'd12;
  localparam logic [4:0] RSN_HUM_WARN_LOW    = 5'd13;
  localparam logic [4:0] RSN_HUM_WARN_HIGH   = 5'd14;
  localparam logic [4:0] RSN_TILT_WARN       = 5'd15;
  localparam logic [4:0] RSN_VIB_WARN        = 5'd16;
  localparam logic [4:0] RSN_ALL_OPTIMAL     = 5'd17;

  // Temperature states.
  localparam logic [1:0] TS_SENSOR_ERROR = 2'd0;
  localparam logic [1:0] TS_CRIT_HIGH    = 2'd1;
  localparam logic [1:0] TS_WARN_HIGH    = 2'd2;
  localparam logic [1:0] TS_OPTIMAL      = 2'd3;

  // Humidity states.
  localparam logic [2:0] HS_SENSOR_ERROR = 3'd0;
  localparam logic [2:0] HS_CRIT_LOW     = 3'd1;
  localparam logic [2:0] HS_CRIT_HIGH    = 3'd2;
  localparam logic [2:0] HS_WARN_LOW     = 3'd3;
  localparam logic [2:0] HS_WARN_HIGH    = 3'd4;
  localparam logic [2:0] HS_OPTIMAL      = 3'd5;

  // Position states.
  localparam logic [2:0] PS_SENSOR_ERROR = 3'd0;
  localparam logic [2:0] PS_TILT_CRIT    = 3'd1;
  localparam logic [2:0] PS_VIB_CRIT     = 3'd2;
  localparam logic [2:0] PS_TILT_WARN    = 3'd3;
  localparam logic [2:0] PS_VIB_WARN     = 3'd4;
  localparam logic [2:0] PS_NOT_VERTICAL = 3'd5;
  localparam logic [2:0] PS_OPTIMAL      = 3'd6;

  typedef struct packed {
    logic signed [11:0] temp_critical;
    logic signed [11:0] temp_optimal_max;
    logic [39:0]        humidity_limits;
    logic [10:0]        tilt_crit_lim;
    logic [10:0]        tilt_warn_lim;
    logic [13:0]        vib_crit_lim;
    logic [13:0]        vib_warn_lim;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         door_security;
    logic               network_up;
    logic               upright;
    logic               motion_sensor_ok;
    logic [13:0]        vibration;
    logic [10:0]        tilt;
    logic               climate_sensor_ok;
    logic [9:0]         humidity;
    logic signed [11:0] temperature;
  } item_t;

  typedef struct packed {
    logic [2:0] door_state_out;
    logic [2:0] position_state;
    logic [2:0] humidity_state;
    logic [1:0] temperature_state;
    logic [4:0] reason_code;
    logic [2:0] overall_status;
  } result_t;

endpackage

@@ hdl/eac_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Threshold register file
// Holds the seven classification thresholds, written through a plain port.
// ----------------------------------------------------------------------------
module eac_cfg_regs
  import eac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CfgDataWidth-1:0] cfg_wdata,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_critical    <= RST_TEMP_CRITICAL;
      cfg.temp_optimal_max <= RST_TEMP_OPTIMAL_MAX;
      cfg.humidity_limits  <= RST_HUMIDITY_LIMITS;
      cfg.tilt_crit_lim    <= RST_TILT_CRIT;
      cfg.tilt_warn_lim    <= RST_TILT_WARN;
      cfg.vib_crit_lim     <= RST_VIB_CRIT;
      cfg.vib_warn_lim     <= RST_VIB_WARN;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TEMP_CRITICAL:    cfg.temp_critical    <= $signed(cfg_wdata[11:0]);
        REG_TEMP_OPTIMAL_MAX: cfg.temp_optimal_max <= $signed(cfg_wdata[11:0]);
        REG_HUMIDITY_LIMITS:  cfg.humidity_limits  <= cfg_wdata[39:0];
        REG_TILT_CRIT:        cfg.tilt_crit_lim    <= cfg_wdata[10:0];
        REG_TILT_WARN:        cfg.tilt_warn_lim    <= cfg_wdata[10:0];
        REG_VIB_CRIT:         cfg.vib_crit_lim     <= cfg_wdata[13:0];
        REG_VIB_WARN:         cfg.vib_warn_lim     <= cfg_wdata[13:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/eac_classify.sv @@
// ----------------------------------------------------------------------------
// Snapshot classifier
// Threshold comparators and priority encoding of component states, overall
// status and reason code for one snapshot.
// ----------------------------------------------------------------------------
module eac_classify
  import eac_pkg::*;
(
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [HumFieldWidth-1:0] hum_crit_low;
  logic [HumFieldWidth-1:0] hum_warn_low;
  logic [HumFieldWidth-1:0] hum_warn_high;
  logic [HumFieldWidth-1:0] hum_crit_high;
  logic [2:0] door;
  logic [1:0] ts;
  logic [2:0] hs;
  logic [2:0] ps;
  logic       door_crit;
  logic       door_warn;
  logic [4:0] door_reason;

  assign hum_crit_low  = cfg.humidity_limits[9:0];
  assign hum_warn_low  = cfg.humidity_limits[19:10];
  assign hum_warn_high = cfg.humidity_limits[29:20];
  assign hum_crit_high = cfg.humidity_limits[39:30];

  // Codes above lock error saturate to lock error.
  assign door = (item.door_security > DOOR_LOCK_FAULT) ? DOOR_LOCK_FAULT
                                                       : item.door_security;

  always_comb begin
    priority if (!item.climate_sensor_ok)                         ts = TS_SENSOR_ERROR;
    else if ($signed(item.temperature) >= $signed(cfg.temp_critical)) ts = TS_CRIT_HIGH;
    else if ($signed(item.temperature) > $signed(cfg.temp_optimal_max)) ts = TS_WARN_HIGH;
    else                                                          ts = TS_OPTIMAL;
  end

  always_comb begin
    priority if (!item.climate_sensor_ok)      hs = HS_SENSOR_ERROR;
    else if (item.humidity <= hum_crit_low)    hs = HS_CRIT_LOW;
    else if (item.humidity >= hum_crit_high)   hs = HS_CRIT_HIGH;
    else if (item.humidity <= hum_warn_low)    hs = HS_WARN_LOW;
    else if (item.humidity >= hum_warn_high)   hs = HS_WARN_HIGH;
    else                                       hs = HS_OPTIMAL;
  end

  always_comb begin
    priority if (!item.motion_sensor_ok)           ps = PS_SENSOR_ERROR;
    else if (item.tilt >= cfg.tilt_crit_lim)       ps = PS_TILT_CRIT;
    else if (item.vibration >= cfg.vib_crit_lim)   ps = PS_VIB_CRIT;
    else if (item.tilt >= cfg.tilt_warn_lim)       ps = PS_TILT_WARN;
    else if (item.vibration >= cfg.vib_warn_lim)   ps = PS_VIB_WARN;
    else if (!item.upright)                        ps = PS_NOT_VERTICAL;
    else                                           ps = PS_OPTIMAL;
  end

  assign door_crit = (door == DOOR_BREACHED) || (door == DOOR_LOCK_FAULT);
  assign door_warn = (door == DOOR_UNLOCKED) || (door == DOOR_OPEN_OK);

  always_comb begin
    unique case (door)
      DOOR_UNLOCKED: door_reason = RSN_DOOR_UNLOCKED;
      DOOR_OPEN_OK:  door_reason = RSN_DOOR_OPEN_AUTH;
      DOOR_BREACHED: door_reason = RSN_DOOR_FORCED;
      default:       door_reason = RSN_DOOR_LOCK_ERR;
    endcase
  end

  always_comb begin
    result.temperature_state = ts;
    result.humidity_state    = hs;
    result.position_state    = ps;
    result.door_state_out    = door;
    priority if (!item.network_up) begin
      result.overall_status = STATUS_OFFLINE;
      result.reason_code    = RSN_NET_DOWN;
    end else if (!item.climate_sensor_ok || !item.motion_sensor_ok) begin
      result.overall_status = STATUS_SENSOR_ERROR;
      result.reason_code    = !item.climate_sensor_ok ? RSN_CLIMATE_ERR : RSN_MOTION_ERR;
    end else if (door_crit || ts == TS_CRIT_HIGH || hs == HS_CRIT_LOW ||
                 hs == HS_CRIT_HIGH || ps == PS_TILT_CRIT || ps == PS_VIB_CRIT) begin
      result.overall_status = STATUS_CRITICAL;
      priority if (door_crit)          result.reason_code = door_reason;
      else if (ts == TS_CRIT_HIGH)     result.reason_code = RSN_TEMP_CRIT;
      else if (hs == HS_CRIT_LOW)      result.reason_code = RSN_HUM_CRIT_LOW;
      else if (hs == HS_CRIT_HIGH)     result.reason_code = RSN_HUM_CRIT_HIGH;
      else if (ps == PS_TILT_CRIT)     result.reason_code = RSN_TILT_CRIT;
      else                             result.reason_code = RSN_VIB_CRIT;
    end else if (door_warn || ts == TS_WARN_HIGH || hs == HS_WARN_LOW ||
                 hs == HS_WARN_HIGH || ps == PS_TILT_WARN || ps == PS_VIB_WARN) begin
      result.overall_status = STATUS_WARNING;
      priority if (door_warn)          result.reason_code = door_reason;
      else if (ts == TS_WARN_HIGH)     result.reason_code = RSN_TEMP_WARN;
      else if (hs == HS_WARN_LOW)      result.reason_code = RSN_HUM_WARN_LOW;
      else if (hs == HS_WARN_HIGH)     result.reason_code = RSN_HUM_WARN_HIGH;
      else if (ps == PS_TILT_WARN)     result.reason_code = RSN_TILT_WARN;
      else                             result.reason_code = RSN_VIB_WARN;
    end else begin
      result.overall_status = STATUS_OPTIMAL;
      result.reason_code    = RSN_ALL_OPTIMAL;
    end
  end

endmodule

@@ hdl/environment_alarm_classifier.sv @@
// ----------------------------------------------------------------------------
// Environment alarm classifier
// Classifies environment snapshots against programmable thresholds.
// ----------------------------------------------------------------------------
// Each input beat is one snapshot; each output beat is its classification.
// The block takes one beat per clock while the output accepts results, and
// passes each beat through the input register and then the result register,
// with the comparator and priority logic between them. The input
// register takes a new beat whenever it is empty or its beat moves on to the
// result register, so the block holds up to two beats and stalls its input
// only when a result waits at the output and the input register is full.
// Thresholds are written through the cfg port and should only change while
// no beat is in flight.
module environment_alarm_classifier
  import eac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [11:0] temperature, [21:12] humidity, [22] climate_sensor_ok, [33:23] tilt,
  // [47:34] vibration, [48] motion_sensor_ok, [49] upright, [50] network_up,
  // [53:51] door_security, [55:54] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [2:0] overall_status, [7:3] reason_code, [9:8] temperature_state,
  // [12:10] humidity_state, [15:13] position_state, [18:16] door_state_out,
  // [23:19] zero
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    cfg_wr_en,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CfgDataWidth-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t result_next;
  result_t result;
  logic    out_valid;
  logic    out_advance;

  eac_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  eac_classify u_classify (
    .item   (in_item),
    .cfg    (cfg),
    .result (result_next)
  );

  assign out_advance   = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= s_axis_tdata[$bits(item_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataWidth - $bits(result_t)){1'b0}}, result};

endmodule
